### rtl/core/tfp_pkg.sv
// Shared types and constants for the telemetry frame parser.
package tfp_pkg;

  // Number of payload bytes kept for decoding (default and minimum).
  localparam int unsigned DECODED_BYTES_DEF = 14;

  // Length byte counts the header and check bytes on top of the payload.
  localparam logic [7:0] FRAME_OVERHEAD = 8'd6;

  // Configuration port shape.
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_START_BYTE   = 3'd0,
    CFG_MAX_LENGTH   = 3'd1,
    CFG_OWN_SENDER   = 3'd2,
    CFG_POSITION_ID  = 3'd3,
    CFG_LINK_ERR_ID  = 3'd4
  } cfg_index_e;

  // Register reset values.
  localparam logic [7:0] START_BYTE_RST       = 8'd153;
  localparam logic [7:0] MAX_LENGTH_RST       = 8'd64;
  localparam logic [7:0] OWN_SENDER_RST       = 8'd1;
  localparam logic [7:0] POSITION_MSG_ID_RST  = 8'd1;
  localparam logic [7:0] LINK_ERR_MSG_ID_RST  = 8'd2;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_POS_OK     = 3'd0,
    ST_LINK_OK    = 3'd1,
    ST_BAD_LEN    = 3'd2,
    ST_BAD_SENDER = 3'd3,
    ST_BAD_MSGID  = 3'd4,
    ST_CHECK_A    = 3'd5,
    ST_CHECK_B    = 3'd6
  } status_e;

endpackage

### rtl/core/telemetry_frame_parser.sv
// Top level of the telemetry frame parser: byte-wise frame decode with check bytes.
//
// Usage: feed the received serial stream one byte per item on the input
// channel (in_valid_i / in_stall_o / rx_byte_i). The parser hunts for the
// start byte, reads length, sender id and message id, collects the payload
// and verifies the two Fletcher-style check bytes. Every frame that ends,
// good or bad, yields exactly one result item on the output channel
// (out_valid_o / out_stall_i plus the field ports); idle bytes yield none.
// Latency: a result is visible the cycle after the byte that completes or
// breaks the frame. Throughput: one byte per cycle unless stalled; each byte
// is a single state update from the input port into the state and result registers.
// Stall: a held result sits in the output register; a new byte is taken
// whenever that register is empty or is being drained in the same cycle,
// so the input stalls only while a result waits and the receiver stalls.
// Reset: the parser returns to the hunt, sums and counters clear, the
// payload store clears to zero and the registers take their reset values.
// Configuration is written through cfg_we_i / cfg_index_i / cfg_wdata_i
// while the parser is idle; indexes beyond the register list are ignored.
module telemetry_frame_parser #(
  parameter int unsigned DECODED_BYTES = tfp_pkg::DECODED_BYTES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // byte input
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [7:0]                         rx_byte_i,
  // result output
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [2:0]                         status_o,
  output logic [7:0]                         sender_field_o,
  output logic [7:0]                         fix_field_o,
  output logic signed [31:0]                 pos_x_o,
  output logic signed [31:0]                 pos_y_o,
  output logic signed [31:0]                 pos_z_o,
  output logic [15:0]                        link_error_count_o,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [tfp_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [tfp_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import tfp_pkg::*;

  localparam int unsigned IDX_W = $clog2(DECODED_BYTES);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN     = 3'd1,
    PH_SENDER  = 3'd2,
    PH_MSGID   = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CKA     = 3'd5,
    PH_CKB     = 3'd6
  } phase_e;

  // Configuration registers
  logic [7:0] start_byte_q, max_length_q, own_sender_q, pos_id_q, link_id_q;

  // Parser state
  phase_e     phase_q, phase_d;
  logic [7:0] sum_a_q, sum_a_d, sum_b_q, sum_b_d;
  logic [7:0] frame_len_q, frame_len_d;
  logic [7:0] pay_cnt_q, pay_cnt_d;
  logic       is_link_q, is_link_d;
  logic [7:0] store_q [DECODED_BYTES];

  // Result register
  logic        out_valid_q, out_valid_d;
  status_e     status_q, status_d;
  logic [7:0]  sender_q, sender_d, fix_q, fix_d;
  logic [31:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d, pos_z_q, pos_z_d;
  logic [15:0] lec_q, lec_d;

  logic       in_acc;
  logic       emit;
  logic       store_we;
  logic [7:0] pay_total;
  logic [7:0] acc_a, acc_b;
  logic [7:0] pay_cnt_inc;

  // Take a byte unless a result waits on a stalled receiver.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // Payload bytes implied by the length byte; short lengths carry none.
  assign pay_total   = (frame_len_q < FRAME_OVERHEAD) ? 8'd0 : frame_len_q - FRAME_OVERHEAD;
  assign acc_a       = sum_a_q + rx_byte_i;
  assign acc_b       = sum_b_q + acc_a;
  assign pay_cnt_inc = pay_cnt_q + 8'd1;

  // Keep only the leading payload bytes; the rest still enter the sums.
  assign store_we = in_acc && (phase_q == PH_PAYLOAD) && (pay_cnt_q < 8'(DECODED_BYTES));

  always_comb begin
    phase_d     = phase_q;
    sum_a_d     = sum_a_q;
    sum_b_d     = sum_b_q;
    frame_len_d = frame_len_q;
    pay_cnt_d   = pay_cnt_q;
    is_link_d   = is_link_q;
    emit        = 1'b0;
    status_d    = status_q;
    sender_d    = '0;
    fix_d       = '0;
    pos_x_d     = '0;
    pos_y_d     = '0;
    pos_z_d     = '0;
    lec_d       = '0;

    if (in_acc) begin
      unique case (phase_q)
        PH_LEN: begin
          frame_len_d = rx_byte_i;
          sum_a_d     = acc_a;
          sum_b_d     = acc_b;
          if (rx_byte_i > max_length_q) begin
            emit     = 1'b1;
            status_d = ST_BAD_LEN;
            phase_d  = PH_HUNT;
          end else begin
            phase_d = PH_SENDER;
          end
        end
        PH_SENDER: begin
          if (rx_byte_i != own_sender_q) begin
            emit     = 1'b1;
            status_d = ST_BAD_SENDER;
            phase_d  = PH_HUNT;
          end else begin
            sum_a_d = acc_a;
            sum_b_d = acc_b;
            phase_d = PH_MSGID;
          end
        end
        PH_MSGID: begin
          // Position wins when both ids are equal.
          if (rx_byte_i == pos_id_q || rx_byte_i == link_id_q) begin
            is_link_d = (rx_byte_i != pos_id_q);
            sum_a_d   = acc_a;
            sum_b_d   = acc_b;
            pay_cnt_d = '0;
            phase_d   = (pay_total == 8'd0) ? PH_CKA : PH_PAYLOAD;
          end else begin
            emit     = 1'b1;
            status_d = ST_BAD_MSGID;
            phase_d  = PH_HUNT;
          end
        end
        PH_PAYLOAD: begin
          sum_a_d   = acc_a;
          sum_b_d   = acc_b;
          pay_cnt_d = pay_cnt_inc;
          if (pay_cnt_inc >= pay_total) begin
            phase_d = PH_CKA;
          end
        end
        PH_CKA: begin
          if (rx_byte_i != sum_a_q) begin
            emit     = 1'b1;
            status_d = ST_CHECK_A;
            phase_d  = PH_HUNT;
          end else begin
            phase_d = PH_CKB;
          end
        end
        PH_CKB: begin
          emit    = 1'b1;
          phase_d = PH_HUNT;
          if (rx_byte_i != sum_b_q) begin
            status_d = ST_CHECK_B;
          end else if (is_link_q) begin
            status_d = ST_LINK_OK;
            lec_d    = {store_q[5], store_q[4]};
          end else begin
            status_d = ST_POS_OK;
            sender_d = store_q[0];
            fix_d    = store_q[1];
            pos_x_d  = {store_q[5], store_q[4], store_q[3], store_q[2]};
            pos_y_d  = {store_q[9], store_q[8], store_q[7], store_q[6]};
            pos_z_d  = {store_q[13], store_q[12], store_q[11], store_q[10]};
          end
        end
        default: begin
          // Hunt; unused codes behave the same.
          phase_d = PH_HUNT;
          if (rx_byte_i == start_byte_q) begin
            sum_a_d = '0;
            sum_b_d = '0;
            phase_d = PH_LEN;
          end
        end
      endcase
    end

    // Load a fresh result, drop a delivered one, hold a stalled one.
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      sum_a_q     <= '0;
      sum_b_q     <= '0;
      frame_len_q <= '0;
      pay_cnt_q   <= '0;
      is_link_q   <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= ST_POS_OK;
      sender_q    <= '0;
      fix_q       <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      pos_z_q     <= '0;
      lec_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      sum_a_q     <= sum_a_d;
      sum_b_q     <= sum_b_d;
      frame_len_q <= frame_len_d;
      pay_cnt_q   <= pay_cnt_d;
      is_link_q   <= is_link_d;
      out_valid_q <= out_valid_d;
      // Result payload: load only with a new result.
      if (emit) begin
        status_q <= status_d;
        sender_q <= sender_d;
        fix_q    <= fix_d;
        pos_x_q  <= pos_x_d;
        pos_y_q  <= pos_y_d;
        pos_z_q  <= pos_z_d;
        lec_q    <= lec_d;
      end
    end
  end

  // Payload store; stale bytes of earlier frames are reported, so clear on reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DECODED_BYTES; i++) begin
        store_q[i] <= '0;
      end
    end else if (store_we) begin
      store_q[pay_cnt_q[IDX_W-1:0]] <= rx_byte_i;
    end
  end

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= START_BYTE_RST;
      max_length_q <= MAX_LENGTH_RST;
      own_sender_q <= OWN_SENDER_RST;
      pos_id_q     <= POSITION_MSG_ID_RST;
      link_id_q    <= LINK_ERR_MSG_ID_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_START_BYTE:  start_byte_q <= cfg_wdata_i;
        CFG_MAX_LENGTH:  max_length_q <= cfg_wdata_i;
        CFG_OWN_SENDER:  own_sender_q <= cfg_wdata_i;
        CFG_POSITION_ID: pos_id_q     <= cfg_wdata_i;
        CFG_LINK_ERR_ID: link_id_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign sender_field_o     = sender_q;
  assign fix_field_o        = fix_q;
  assign pos_x_o            = pos_x_q;
  assign pos_y_o            = pos_y_q;
  assign pos_z_o            = pos_z_q;
  assign link_error_count_o = lec_q;

endmodule

### tb/tb_telemetry_frame_parser.sv
// Self-checking testbench for the telemetry frame parser: directed rows, then random frames.
module tb_telemetry_frame_parser;
  import tfp_pkg::*;

  localparam int unsigned RESET_CYCLES    = 6;
  localparam int unsigned DRAIN_CYCLES    = 4;     // result shows up the cycle after its byte
  localparam int unsigned QUIET_LIMIT     = 2000;  // cycles without any handshake
  localparam int unsigned NUM_PHASES      = 6;
  localparam int unsigned BYTES_PER_PHASE = 95;
  localparam int unsigned IDLE_BUSY_PCT   = 74;
  localparam int unsigned IDLE_BOTH_PCT   = 34;
  localparam int unsigned STORE_BYTES     = DECODED_BYTES_DEF;

  // Index past the register list; the parser must ignore it.
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_IDX = '1;

  localparam bit PRED_ROW  = 1'b0;
  localparam bit TYPED_ROW = 1'b1;

  typedef enum logic [2:0] {
    S_HUNT, S_LEN, S_SENDER, S_MSGID, S_PAYLOAD, S_CKA, S_CKB
  } parse_state_e;

  typedef enum int {
    F_NONE, F_LEN, F_SENDER, F_MSGID, F_CKA, F_CKB, F_TRUNC
  } frame_fault_e;

  typedef struct {
    status_e            status;
    logic [7:0]         sender;
    logic [7:0]         fix;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [15:0]        link_cnt;
  } frame_result_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    status_e    st;
  } dir_row_t;

  // Directed bytes under reset settings; typed rows carry an obvious error or after-reset result.
  localparam dir_row_t DIR_ROWS [27] = '{
    '{8'hFF,          PRED_ROW,  ST_POS_OK},      // idle byte in the hunt
    '{START_BYTE_RST, PRED_ROW,  ST_POS_OK},
    '{8'hFF,          TYPED_ROW, ST_BAD_LEN},     // largest length byte
    '{START_BYTE_RST, PRED_ROW,  ST_POS_OK},
    '{8'h06,          PRED_ROW,  ST_POS_OK},
    '{8'h00,          TYPED_ROW, ST_BAD_SENDER},
    '{START_BYTE_RST, PRED_ROW,  ST_POS_OK},
    '{8'h00,          PRED_ROW,  ST_POS_OK},
    '{OWN_SENDER_RST, PRED_ROW,  ST_POS_OK},
    '{8'hFF,          TYPED_ROW, ST_BAD_MSGID},
    '{START_BYTE_RST, PRED_ROW,  ST_POS_OK},      // short frame, link error message
    '{8'h00,          PRED_ROW,  ST_POS_OK},
    '{OWN_SENDER_RST, PRED_ROW,  ST_POS_OK},
    '{LINK_ERR_MSG_ID_RST, PRED_ROW, ST_POS_OK},
    '{8'h03,          PRED_ROW,  ST_POS_OK},
    '{8'h04,          TYPED_ROW, ST_LINK_OK},     // store still zero after reset
    '{START_BYTE_RST, PRED_ROW,  ST_POS_OK},
    '{8'h00,          PRED_ROW,  ST_POS_OK},
    '{OWN_SENDER_RST, PRED_ROW,  ST_POS_OK},
    '{POSITION_MSG_ID_RST, PRED_ROW, ST_POS_OK},
    '{8'h00,          TYPED_ROW, ST_CHECK_A},
    '{START_BYTE_RST, PRED_ROW,  ST_POS_OK},
    '{8'h00,          PRED_ROW,  ST_POS_OK},
    '{OWN_SENDER_RST, PRED_ROW,  ST_POS_OK},
    '{POSITION_MSG_ID_RST, PRED_ROW, ST_POS_OK},
    '{8'h02,          PRED_ROW,  ST_POS_OK},
    '{8'h00,          TYPED_ROW, ST_CHECK_B}
  };

  logic                   clk_i;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic [7:0]             rx_byte_i   = 8'h00;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [2:0]             status_o;
  logic [7:0]             sender_field_o;
  logic [7:0]             fix_field_o;
  logic signed [31:0]     pos_x_o;
  logic signed [31:0]     pos_y_o;
  logic signed [31:0]     pos_z_o;
  logic [15:0]            link_error_count_o;
  logic                   cfg_we_i    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;

  telemetry_frame_parser u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .rx_byte_i,
    .out_valid_o,
    .out_stall_i,
    .status_o,
    .sender_field_o,
    .fix_field_o,
    .pos_x_o,
    .pos_y_o,
    .pos_z_o,
    .link_error_count_o,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i
  );

  // Parser mirror: settings and frame state.
  logic [7:0]   cfg_start   = START_BYTE_RST;
  logic [7:0]   cfg_max_len = MAX_LENGTH_RST;
  logic [7:0]   cfg_sender  = OWN_SENDER_RST;
  logic [7:0]   cfg_pos_id  = POSITION_MSG_ID_RST;
  logic [7:0]   cfg_link_id = LINK_ERR_MSG_ID_RST;
  parse_state_e ph          = S_HUNT;
  logic [7:0]   acc_a       = '0;
  logic [7:0]   acc_b       = '0;
  logic [7:0]   frame_len   = '0;
  logic [7:0]   pay_cnt     = '0;
  logic         link_frame  = 1'b0;
  logic [7:0]   pay_store [STORE_BYTES] = '{default: 8'h00};

  frame_result_t exp_results [$];
  int unsigned   errors         = 0;
  int unsigned   send_idle_pct  = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   phase_bytes    = 0;
  int unsigned   quiet_cycles   = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic frame_result_t blank_result(status_e s);
    frame_result_t r;
    r.status   = s;
    r.sender   = '0;
    r.fix      = '0;
    r.px       = '0;
    r.py       = '0;
    r.pz       = '0;
    r.link_cnt = '0;
    return r;
  endfunction

  function automatic logic [7:0] payload_len();
    return (frame_len < FRAME_OVERHEAD) ? 8'd0 : frame_len - FRAME_OVERHEAD;
  endfunction

  // Advance the mirror by one accepted byte; return 1 when the byte closes a frame.
  function automatic bit decode_byte(input logic [7:0] b, output frame_result_t r);
    r = blank_result(ST_POS_OK);
    case (ph)
      S_LEN: begin
        frame_len = b;
        acc_a = acc_a + b;
        acc_b = acc_b + acc_a;
        if (b > cfg_max_len) begin
          r  = blank_result(ST_BAD_LEN);
          ph = S_HUNT;
          return 1'b1;
        end
        ph = S_SENDER;
      end
      S_SENDER: begin
        if (b != cfg_sender) begin
          r  = blank_result(ST_BAD_SENDER);
          ph = S_HUNT;
          return 1'b1;
        end
        acc_a = acc_a + b;
        acc_b = acc_b + acc_a;
        ph = S_MSGID;
      end
      S_MSGID: begin
        // position id wins when both ids match
        if (b == cfg_pos_id) begin
          link_frame = 1'b0;
        end else if (b == cfg_link_id) begin
          link_frame = 1'b1;
        end else begin
          r  = blank_result(ST_BAD_MSGID);
          ph = S_HUNT;
          return 1'b1;
        end
        acc_a   = acc_a + b;
        acc_b   = acc_b + acc_a;
        pay_cnt = '0;
        ph = (payload_len() == 8'd0) ? S_CKA : S_PAYLOAD;
      end
      S_PAYLOAD: begin
        // keep only the decoded bytes; the rest still feed the sums
        if (pay_cnt < STORE_BYTES) pay_store[pay_cnt] = b;
        acc_a   = acc_a + b;
        acc_b   = acc_b + acc_a;
        pay_cnt = pay_cnt + 8'd1;
        if (pay_cnt >= payload_len()) ph = S_CKA;
      end
      S_CKA: begin
        if (b != acc_a) begin
          r  = blank_result(ST_CHECK_A);
          ph = S_HUNT;
          return 1'b1;
        end
        ph = S_CKB;
      end
      S_CKB: begin
        ph = S_HUNT;
        if (b != acc_b) begin
          r = blank_result(ST_CHECK_B);
        end else if (link_frame) begin
          r = blank_result(ST_LINK_OK);
          r.link_cnt = {pay_store[5], pay_store[4]};
        end else begin
          r.sender = pay_store[0];
          r.fix    = pay_store[1];
          r.px     = {pay_store[5], pay_store[4], pay_store[3], pay_store[2]};
          r.py     = {pay_store[9], pay_store[8], pay_store[7], pay_store[6]};
          r.pz     = {pay_store[13], pay_store[12], pay_store[11], pay_store[10]};
        end
        return 1'b1;
      end
      default: begin
        ph = S_HUNT;
        if (b == cfg_start) begin
          acc_a = '0;
          acc_b = '0;
          ph = S_LEN;
        end
      end
    endcase
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Offer one byte; hold it until taken, then advance the mirror.
  task automatic send_byte(input logic [7:0] b, input bit typed = PRED_ROW,
                           input status_e st = ST_POS_OK);
    frame_result_t r;
    bit            got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    got = decode_byte(b, r);
    if (typed) exp_results.push_back(blank_result(st));
    else if (got) exp_results.push_back(r);
    phase_bytes++;
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_START_BYTE:  cfg_start   = val;
      CFG_MAX_LENGTH:  cfg_max_len = val;
      CFG_OWN_SENDER:  cfg_sender  = val;
      CFG_POSITION_ID: cfg_pos_id  = val;
      CFG_LINK_ERR_ID: cfg_link_id = val;
      default: ;
    endcase
  endtask

  // Drop valid, wait for every pending result, then let the pipeline go quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (exp_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_settings(input int unsigned idx);
    logic [7:0] id;
    case (idx)
      1: begin
        cfg_write(CFG_START_BYTE, 8'h00);
        cfg_write(CFG_MAX_LENGTH, 8'hFF);
        cfg_write(CFG_OWN_SENDER, 8'hFF);
        cfg_write(CFG_POSITION_ID, 8'h00);
        cfg_write(CFG_LINK_ERR_ID, 8'hFF);
        cfg_write(CFG_UNUSED_IDX, 8'hA5);
      end
      2: begin
        // only zero-length frames fit; both message ids equal
        cfg_write(CFG_START_BYTE, 8'hFF);
        cfg_write(CFG_MAX_LENGTH, 8'h00);
        cfg_write(CFG_OWN_SENDER, 8'h00);
        cfg_write(CFG_POSITION_ID, 8'hFF);
        cfg_write(CFG_LINK_ERR_ID, 8'hFF);
      end
      3: begin
        cfg_write(CFG_START_BYTE, 8'($urandom_range(255)));
        cfg_write(CFG_MAX_LENGTH, 8'($urandom_range(255)));
        cfg_write(CFG_OWN_SENDER, 8'($urandom_range(255)));
        cfg_write(CFG_POSITION_ID, 8'($urandom_range(255)));
        cfg_write(CFG_LINK_ERR_ID, 8'($urandom_range(255)));
      end
      4: begin
        id = 8'($urandom_range(255));
        cfg_write(CFG_START_BYTE, 8'($urandom_range(255)));
        cfg_write(CFG_MAX_LENGTH, FRAME_OVERHEAD + 8'(STORE_BYTES));
        cfg_write(CFG_OWN_SENDER, 8'($urandom_range(255)));
        cfg_write(CFG_POSITION_ID, id);
        cfg_write(CFG_LINK_ERR_ID, id + 8'd1);
      end
      5: begin
        cfg_write(CFG_START_BYTE, START_BYTE_RST);
        cfg_write(CFG_MAX_LENGTH, MAX_LENGTH_RST);
        cfg_write(CFG_OWN_SENDER, OWN_SENDER_RST);
        cfg_write(CFG_POSITION_ID, POSITION_MSG_ID_RST);
        cfg_write(CFG_LINK_ERR_ID, LINK_ERR_MSG_ID_RST);
      end
      default: ;
    endcase
    cfg_we_i <= 1'b0;
  endtask

  // Build one random frame, mostly well formed; cut it after a length, sender or id fault.
  task automatic send_frame();
    logic [7:0]   fr [$];
    logic [7:0]   sa, sb, sender_v, msg_v, v;
    frame_fault_e fault;
    int unsigned  pick, flen, cut;
    sa = '0;
    sb = '0;
    if ($urandom_range(99) < 15) repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
    fault = ($urandom_range(99) < 72) ? F_NONE : frame_fault_e'($urandom_range(F_TRUNC, F_LEN));
    if (fault == F_LEN && cfg_max_len == 8'hFF) fault = F_NONE;
    if (fault == F_LEN) begin
      flen = $urandom_range(255, int'(cfg_max_len) + 1);
    end else begin
      pick = $urandom_range(99);
      if (pick < 10)      flen = $urandom_range(5, 0);
      else if (pick < 90) flen = $urandom_range(20, 6);
      else if (pick < 97) flen = $urandom_range(40, 21);
      else                flen = cfg_max_len;
      if (flen > cfg_max_len) flen = $urandom_range(cfg_max_len, 0);
    end
    sender_v = cfg_sender;
    if (fault == F_SENDER) sender_v = cfg_sender ^ 8'($urandom_range(255, 1));
    if (fault == F_MSGID) begin
      do msg_v = 8'($urandom_range(255)); while (msg_v == cfg_pos_id || msg_v == cfg_link_id);
    end else begin
      msg_v = $urandom_range(1) ? cfg_pos_id : cfg_link_id;
    end
    fr = '{cfg_start, 8'(flen), sender_v, msg_v};
    for (int i = int'(FRAME_OVERHEAD); i < int'(flen); i++) begin
      // lean on sign and range edges of the position words
      case ($urandom_range(7))
        0:       v = 8'h00;
        1:       v = 8'hFF;
        2:       v = 8'h7F;
        3:       v = 8'h80;
        default: v = 8'($urandom_range(255));
      endcase
      fr.push_back(v);
    end
    for (int i = 1; i < fr.size(); i++) begin
      sa = sa + fr[i];
      sb = sb + sa;
    end
    fr.push_back((fault == F_CKA) ? sa ^ 8'($urandom_range(255, 1)) : sa);
    fr.push_back((fault == F_CKB) ? sb ^ 8'($urandom_range(255, 1)) : sb);
    case (fault)
      F_LEN:    cut = 2;
      F_SENDER: cut = 3;
      F_MSGID:  cut = 4;
      F_TRUNC:  cut = $urandom_range(fr.size() - 1, 1);
      default:  cut = fr.size();
    endcase
    for (int i = 0; i < int'(cut); i++) send_byte(fr[i]);
  endtask

  // Receiver: stall at the rate of the current phase.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Compare each taken result against the oldest expectation.
  always @(posedge clk_i) begin
    frame_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (exp_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result, status %0d", status_o));
      end else begin
        e = exp_results.pop_front();
        if (status_o !== e.status)
          report_mismatch($sformatf("status %0d, want %0d", status_o, e.status));
        if (sender_field_o !== e.sender)
          report_mismatch($sformatf("sender_field %h, want %h", sender_field_o, e.sender));
        if (fix_field_o !== e.fix)
          report_mismatch($sformatf("fix_field %h, want %h", fix_field_o, e.fix));
        if (pos_x_o !== e.px)
          report_mismatch($sformatf("pos_x %0d, want %0d", pos_x_o, e.px));
        if (pos_y_o !== e.py)
          report_mismatch($sformatf("pos_y %0d, want %0d", pos_y_o, e.py));
        if (pos_z_o !== e.pz)
          report_mismatch($sformatf("pos_z %0d, want %0d", pos_z_o, e.pz));
        if (link_error_count_o !== e.link_cnt)
          report_mismatch($sformatf("link_error_count %0d, want %0d",
                                    link_error_count_o, e.link_cnt));
      end
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles > QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int unsigned ph_i;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_ROWS[i]) send_byte(DIR_ROWS[i].rx, DIR_ROWS[i].typed, DIR_ROWS[i].st);

    for (ph_i = 0; ph_i < NUM_PHASES; ph_i++) begin
      settle();
      apply_settings(ph_i);
      case (ph_i % 4)
        0: begin send_idle_pct = 0;             recv_stall_pct = 0;             end
        1: begin send_idle_pct = IDLE_BUSY_PCT; recv_stall_pct = 0;             end
        2: begin send_idle_pct = 0;             recv_stall_pct = IDLE_BUSY_PCT; end
        default: begin
          send_idle_pct  = IDLE_BOTH_PCT;
          recv_stall_pct = IDLE_BOTH_PCT;
        end
      endcase
      phase_bytes = 0;
      while (phase_bytes < BYTES_PER_PHASE) send_frame();
    end

    settle();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/tfp_pkg.sv
rtl/core/telemetry_frame_parser.sv
tb/tb_telemetry_frame_parser.sv
